FILE: rtl/tma_pkg.sv
// shared types, constants and codes for the trimmed moving average filter
package tma_pkg;

   localparam int MAX_WINDOW_DEFAULT = 16;

   localparam int SAMPLE_W    = 32;
   localparam int WLEN_W      = 5;
   localparam int TRIM_W      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM_PER_SIDE = 2'd1;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd16;
   localparam logic [TRIM_W-1:0] TRIM_RESET = 3'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SORT,
      ST_ACCUM,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_step;
      logic sort_step;
      logic acc_step;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic load_done;
      logic sort_done;
      logic acc_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/tma_ctrl.sv
// sequencer for the trimmed moving average filter
module tma_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tma_pkg::status_type status,
   output tma_pkg::cmd_type    cmd
);
   import tma_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.load_done) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (status.sort_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (status.acc_done) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOAD:     cmd.load_step = 1'b1;
         ST_SORT:     cmd.sort_step = 1'b1;
         ST_ACCUM:    cmd.acc_step  = 1'b1;
         ST_DIV_INIT: cmd.div_init  = 1'b1;
         ST_DIVIDE:   cmd.div_step  = 1'b1;
         ST_FINISH:   cmd.out_load  = status.out_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tma_datapath.sv
// window store, sorter, accumulator, divider and result register
module tma_datapath #(
   parameter int MAX_WINDOW = tma_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tma_pkg::cmd_type                     cmd,
   output tma_pkg::status_type                  status,
   input  logic                                 csr_write_enable,
   input  logic [tma_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tma_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [tma_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [tma_pkg::SAMPLE_W-1:0]  rsp_average,
   output logic                                 rsp_window_full
);
   import tma_pkg::*;

   localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W    = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int STEP_MAX = (SUM_W > MAX_WINDOW) ? SUM_W : MAX_WINDOW;
   localparam int STEP_W   = $clog2(STEP_MAX + 2);
   localparam int CMP_W    = CNT_W + TRIM_W + 1;

   // window store
   logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic                       rd_en;

   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic [TRIM_W-1:0] trim_ff, trim_in;
   logic              clear;

   logic [IDX_W-1:0]  wpos_ff, wpos_in, wpos_cur;
   logic [CNT_W-1:0]  fill_ff, fill_in, fill_new;
   logic [CNT_W-1:0]  eff_w;
   logic [TRIM_W-1:0] eff_t, t_used;

   logic [CNT_W-1:0]  n_ff, n_in;
   logic [TRIM_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              full_ff, full_in;

   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;

   logic signed [SAMPLE_W-1:0] cell_ff [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] cell_in [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] net_cell [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]      cvld_ff, cvld_in, net_vld;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    neg_ff, neg_in;
   logic [CNT_W:0]          rem_ff, rem_in, rem_sh;
   logic [SUM_W-1:0]        quo_ff, quo_in, quo_res;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;
   logic                       rsp_full_ff, rsp_full_in;

   logic step_done;

   // register writes
   always_comb begin
      wlen_in = wlen_ff;
      trim_in = trim_ff;
      clear   = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wlen_in = csr_wdata[WLEN_W-1:0];
               clear   = 1'b1;
            end
            CSR_TRIM_PER_SIDE: begin
               trim_in = csr_wdata[TRIM_W-1:0];
               clear   = 1'b1;
            end
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   // clamped window and trim
   always_comb begin
      if (wlen_ff == '0) begin
         eff_w = CNT_W'(1);
      end else if (int'(wlen_ff) > MAX_WINDOW) begin
         eff_w = CNT_W'(MAX_WINDOW);
      end else begin
         eff_w = CNT_W'(wlen_ff);
      end
      if ((CMP_W'(trim_ff) << 1) >= CMP_W'(eff_w)) begin
         eff_t = TRIM_W'((eff_w - CNT_W'(1)) >> 1);
      end else begin
         eff_t = trim_ff;
      end
   end

   // write position and fill on a new request, cleared on a register write
   always_comb begin
      wpos_cur = (CNT_W'(wpos_ff) >= eff_w) ? '0 : wpos_ff;
      fill_new = (fill_ff < eff_w) ? fill_ff + CNT_W'(1) : fill_ff;
      t_used   = (fill_new == eff_w) ? eff_t : '0;
      wpos_in  = wpos_ff;
      fill_in  = fill_ff;
      n_in     = n_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      div_in   = div_ff;
      full_in  = full_ff;
      if (clear) begin
         wpos_in = '0;
         fill_in = '0;
      end else if (cmd.accept) begin
         wpos_in = (CNT_W'(wpos_cur) + CNT_W'(1) == eff_w) ? '0 : wpos_cur + IDX_W'(1);
         fill_in = fill_new;
      end
      if (cmd.accept) begin
         n_in    = fill_new;
         lo_in   = t_used;
         hi_in   = fill_new - CNT_W'(t_used);
         div_in  = fill_new - CNT_W'(CMP_W'(t_used) << 1);
         full_in = (fill_new == eff_w);
      end
   end

   // phase counter
   always_comb begin
      status.load_done = (cnt_ff == STEP_W'(n_ff));
      status.sort_done = (cnt_ff == STEP_W'(n_ff));
      status.acc_done  = (cnt_ff == STEP_W'(n_ff) - STEP_W'(1));
      status.div_done  = (cnt_ff == STEP_W'(SUM_W - 1));
      status.out_free  = !rsp_valid_ff || !rsp_stall;
      step_done = (cmd.load_step && status.load_done) || (cmd.sort_step && status.sort_done)
               || (cmd.acc_step && status.acc_done) || (cmd.div_step && status.div_done);
      rd_en     = cmd.load_step && (cnt_ff < STEP_W'(n_ff));
      rd_vld_in = rd_en;
      cnt_in    = cnt_ff;
      if (cmd.accept || cmd.div_init || step_done) begin
         cnt_in = '0;
      end else if (cmd.load_step || cmd.sort_step || cmd.acc_step || cmd.div_step) begin
         cnt_in = cnt_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wpos_cur] <= req_sample;
      end
      if (rd_en) begin
         rdata_ff <= mem[cnt_ff[IDX_W-1:0]];
      end
   end

   // odd-even transposition pass, empty cells sort above all samples
   always_comb begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
         net_cell[k] = cell_ff[k];
         net_vld[k]  = cvld_ff[k];
      end
      for (int k = 0; k < MAX_WINDOW - 1; k++) begin
         if ((1'(k) == cnt_ff[0]) &&
             ((!cvld_ff[k] && cvld_ff[k+1]) ||
              (cvld_ff[k] && cvld_ff[k+1] && (cell_ff[k] > cell_ff[k+1])))) begin
            net_cell[k]   = cell_ff[k+1];
            net_cell[k+1] = cell_ff[k];
            net_vld[k]    = cvld_ff[k+1];
            net_vld[k+1]  = cvld_ff[k];
         end
      end
   end

   // load, sort and shift out the cells
   always_comb begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
         cell_in[k] = cell_ff[k];
      end
      cvld_in = cvld_ff;
      if (cmd.accept) begin
         cvld_in = '0;
      end else if (rd_vld_ff) begin
         cell_in[0] = rdata_ff;
         cvld_in[0] = 1'b1;
         for (int k = 1; k < MAX_WINDOW; k++) begin
            cell_in[k] = cell_ff[k-1];
            cvld_in[k] = cvld_ff[k-1];
         end
      end else if (cmd.sort_step) begin
         for (int k = 0; k < MAX_WINDOW; k++) begin
            cell_in[k] = net_cell[k];
         end
         cvld_in = net_vld;
      end else if (cmd.acc_step) begin
         for (int k = 0; k < MAX_WINDOW - 1; k++) begin
            cell_in[k] = cell_ff[k+1];
            cvld_in[k] = cvld_ff[k+1];
         end
         cvld_in[MAX_WINDOW-1] = 1'b0;
      end
   end

   // sum of kept samples and bit-serial divide
   always_comb begin
      sum_in = sum_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rem_sh = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
      if (cmd.accept) begin
         sum_in = '0;
      end else if (cmd.acc_step && (cnt_ff >= STEP_W'(lo_ff)) && (cnt_ff < STEP_W'(hi_ff))) begin
         sum_in = sum_ff + SUM_W'(cell_ff[0]);
      end
      if (cmd.div_init) begin
         neg_in = sum_ff[SUM_W-1];
         quo_in = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sh - {1'b0, div_ff};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // result register
   always_comb begin
      quo_res        = neg_ff ? -quo_ff : quo_ff;
      rsp_average_in = rsp_average_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_average_in = $signed(quo_res[SAMPLE_W-1:0]);
         rsp_full_in    = full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= WLEN_RESET;
         trim_ff      <= TRIM_RESET;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         cvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wlen_ff      <= wlen_in;
         trim_ff      <= trim_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         cvld_ff      <= cvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      div_ff         <= div_in;
      full_ff        <= full_in;
      sum_ff         <= sum_in;
      neg_ff         <= neg_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      rsp_average_ff <= rsp_average_in;
      rsp_full_ff    <= rsp_full_in;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         cell_ff[k] <= cell_in[k];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = rsp_average_ff;
   assign rsp_window_full = rsp_full_ff;

endmodule

FILE: rtl/trimmed_moving_average.sv
// top level of the trimmed moving average filter
// Each accepted request writes one signed Q24.8 sample into a circular window
// and yields one response: the truncated mean of the samples held so far while
// the window fills (window_full low), then the mean of the full window with
// trim_per_side samples dropped at each end of its sorted order (window_full
// high). One request is processed at a time, in steps: reading the window
// out of its single-port store, n + 1 passes of the odd-even transposition
// sorter, n being the samples in the window, accumulation of the kept
// samples, and one quotient bit per cycle in the divider. The next request
// is taken while a response still waits in the output register. Writing
// either register empties the window; the user must write registers only
// while the block is idle, which the block itself does not enforce.
module trimmed_moving_average #(
   parameter int MAX_WINDOW = tma_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tma_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tma_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tma_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tma_pkg::SAMPLE_W-1:0]  rsp_average,
   output logic                                 rsp_window_full
);
   import tma_pkg::*;

   cmd_type    cmd;
   status_type status;

   tma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tma_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample       (req_sample),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_average      (rsp_average),
      .rsp_window_full  (rsp_window_full)
   );

`ifndef NO_ASSERTIONS
   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in progress");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result register overwritten while response pending");

   a_response_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("response raised without a finished request");
`endif

endmodule
